/* hw/rtl/obbov_pkg.sv */
// shared types and constants for the oriented box overlap tester
`timescale 1ns / 1ps

package obbov_pkg;

  // parameter defaults
  localparam int COORD_WIDTH_DEF    = 32;
  localparam int AXIS_FRAC_BITS_DEF = 14;

  // input field width
  localparam int IN_W = 32;

  // command kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  // load slots
  localparam logic [2:0] SLOT_CENTER = 3'd0;
  localparam logic [2:0] SLOT_AXIS0  = 3'd1;
  localparam logic [2:0] SLOT_AXIS1  = 3'd2;
  localparam logic [2:0] SLOT_AXIS2  = 3'd3;
  localparam logic [2:0] SLOT_EXT    = 3'd4;

  // candidate axis numbering
  localparam logic [3:0] FACES_PER_BOX = 4'd3;
  localparam logic [3:0] FACE_AXES     = 4'd6;
  localparam logic [3:0] AXIS_LAST     = 4'd14;
  localparam logic [3:0] AXIS_NONE     = 4'd15;

  // input word
  typedef struct packed {
    logic                   kind;
    logic                   box_sel;
    logic [2:0]             slot;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } in_word_t;

  // result word
  typedef struct packed {
    logic       overlap;
    logic [3:0] separating_axis;
  } out_word_t;

endpackage

/* hw/rtl/obb_obb_overlap_test.sv */
// oriented box overlap tester: box storage, sequencer and shared multiply-accumulate unit
// load: written into box storage, no result, busy stays low
// test: stops at the first axis that separates, otherwise tries all 15 axes; each product
//   is split into a low-half pass and a high-half pass through the one shared multiplier
// one test at a time; the result strobe rises in the cycle after the last axis step
// synchronous active-low reset clears the sequencer and zeroes both stored boxes
`timescale 1ns / 1ps

module obb_obb_overlap_test #(
  parameter int COORD_WIDTH    = obbov_pkg::COORD_WIDTH_DEF,
  parameter int AXIS_FRAC_BITS = obbov_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  obbov_pkg::in_word_t  in_data,
  output logic                 out_valid,
  output obbov_pkg::out_word_t out_data
);

  // widths
  localparam int AW = AXIS_FRAC_BITS + 2;
  localparam int CW = COORD_WIDTH;
  localparam int MW = (CW > AW) ? CW : AW;
  localparam int LW = 2 * AW + 1;
  localparam int TW = 3 * AW + 3;
  localparam int XW = TW + 1;
  localparam int XH = (XW + 1) / 2;
  localparam int YW = MW + 1;
  localparam int PW = XH + 1 + YW;
  localparam int WW = 3 * AW + MW + 8;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AX   = 3'd1;
  localparam logic [2:0] S_OP   = 3'd2;
  localparam logic [2:0] S_ZC   = 3'd3;
  localparam logic [2:0] S_RAD  = 3'd4;
  localparam logic [2:0] S_OWN  = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;
  localparam logic [2:0] S_NEXT = 3'd7;

  // dot operations
  localparam logic [1:0] OP_LC = 2'd0;
  localparam logic [1:0] OP_D  = 2'd1;
  localparam logic [1:0] OP_T  = 2'd2;
  localparam logic [1:0] OP_E  = 2'd3;

  function automatic logic [1:0] mod3(input logic [2:0] s);
    if (s >= 3'd6) begin
      return 2'(s - 3'd6);
    end else if (s >= 3'd3) begin
      return 2'(s - 3'd3);
    end
    return s[1:0];
  endfunction

  // box storage
  logic signed [CW-1:0] cen_a_r [3];
  logic signed [CW-1:0] cen_b_r [3];
  logic signed [CW-1:0] ext_a_r [3];
  logic signed [CW-1:0] ext_b_r [3];
  logic signed [AW-1:0] ax_a_r  [9];
  logic signed [AW-1:0] ax_b_r  [9];

  // sequencer
  logic [2:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [3:0] axis_r, axis_nxt;
  logic       b_r, b_nxt;
  logic [1:0] k_r, k_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  // axis and projection values
  logic signed [LW-1:0] l_r [3];
  logic [TW-1:0]        t_r;
  logic [WW-1:0]        dabs_r;
  logic signed [WW-1:0] rsum_r;

  // multiply-accumulate pipeline
  logic signed [XH:0]   xop_r, xop_nxt;
  logic signed [YW-1:0] yop_r;
  logic                 opv_r, ophi_r;
  logic signed [PW-1:0] prod_r;
  logic                 prodv_r, prodhi_r;
  logic signed [WW-1:0] acc_r, acc_nxt;
  logic [WW-1:0]        acc_abs;

  // result
  logic                 out_valid_r, out_valid_nxt;
  obbov_pkg::out_word_t out_r, out_nxt;

  // decode
  logic       accept, is_face, own0, own1, own_b, all_zero, sep;
  logic [1:0] own_idx, xi, xj, term, nterms;
  logic [3:0] xo;
  logic       pass, issue, wb;
  logic [3:0] ax_a_addr, ax_b_addr;
  logic [1:0] ext_addr;
  logic signed [AW-1:0] ax_a_rd, ax_b_rd;
  logic signed [CW-1:0] cen_a_rd, cen_b_rd, ext_a_rd, ext_b_rd, ext_sel;
  logic signed [XW-1:0] xfull;
  logic signed [YW-1:0] yfull;
  logic [3:0] ld_base;
  logic [WW:0] lhs;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign is_face = (axis_r < obbov_pkg::FACE_AXES);
  assign own0    = (axis_r < obbov_pkg::FACES_PER_BOX);
  assign own1    = is_face && !own0;
  assign own_b   = b_r ? own1 : own0;
  assign own_idx = own0 ? axis_r[1:0] : 2'(axis_r - obbov_pkg::FACES_PER_BOX);
  assign xo      = axis_r - obbov_pkg::FACE_AXES;
  assign xi      = (xo >= 4'd6) ? 2'd2 : ((xo >= 4'd3) ? 2'd1 : 2'd0);
  assign xj      = 2'(xo - 4'(xi) * 4'd3);
  assign nterms  = (op_r == OP_LC) ? 2'd2 : ((op_r == OP_E) ? 2'd1 : 2'd3);
  assign term    = cnt_r[2:1];
  assign pass    = cnt_r[0];
  assign issue   = (cnt_r < {1'b0, nterms, 1'b0});
  assign wb      = (cnt_r == ({1'b0, nterms, 1'b0} + 4'd2));
  assign all_zero = (l_r[0] == '0) && (l_r[1] == '0) && (l_r[2] == '0);
  assign acc_abs = acc_r[WW-1] ? WW'(-acc_r) : WW'(acc_r);
  assign lhs     = {1'b0, (dabs_r << AXIS_FRAC_BITS)};
  assign sep     = $signed(lhs) > (WW+1)'(rsum_r);
  assign ld_base = 4'(in_data.slot - 3'd1) * 4'd3;

  // storage read addresses
  always_comb begin
    ax_a_addr = '0;
    ax_b_addr = '0;
    ext_addr  = k_r;
    if (state_r == S_AX) begin
      ax_a_addr = 4'(own_idx) * 4'd3 + 4'(k_r);
      ax_b_addr = ax_a_addr;
    end else if (op_r == OP_LC) begin
      ax_a_addr = 4'(xi) * 4'd3 + 4'(mod3(3'(k_r) + 3'd1 + 3'(term)));
      ax_b_addr = 4'(xj) * 4'd3 + 4'(mod3(3'(k_r) + 3'd2 + {term[0], 1'b0}));
    end else begin
      ax_a_addr = 4'(k_r) * 4'd3 + 4'(term);
      ax_b_addr = ax_a_addr;
    end
    if (state_r == S_OWN) begin
      ext_addr = own_idx;
    end
  end

  assign ax_a_rd  = ax_a_r[ax_a_addr];
  assign ax_b_rd  = ax_b_r[ax_b_addr];
  assign cen_a_rd = cen_a_r[term];
  assign cen_b_rd = cen_b_r[term];
  assign ext_a_rd = ext_a_r[ext_addr];
  assign ext_b_rd = ext_b_r[ext_addr];
  assign ext_sel  = b_r ? ext_b_rd : ext_a_rd;

  // operand selection for the shared multiplier
  always_comb begin
    xfull = '0;
    yfull = '0;
    case (op_r)
      OP_LC: begin
        xfull = XW'(ax_a_rd);
        yfull = term[0] ? -YW'(ax_b_rd) : YW'(ax_b_rd);
      end
      OP_D: begin
        xfull = XW'(l_r[term]);
        yfull = YW'(cen_b_rd) - YW'(cen_a_rd);
      end
      OP_T: begin
        xfull = XW'(l_r[term]);
        yfull = b_r ? YW'(ax_b_rd) : YW'(ax_a_rd);
      end
      default: begin
        xfull = XW'($signed({1'b0, t_r}));
        yfull = YW'(ext_sel);
      end
    endcase
    xop_nxt = pass ? (XH+1)'($signed(xfull[XW-1:XH])) : $signed({1'b0, xfull[XH-1:0]});
  end

  // accumulator
  always_comb begin
    acc_nxt = acc_r;
    if (prodv_r) begin
      acc_nxt = acc_r + (prodhi_r ? (WW'(prod_r) <<< XH) : WW'(prod_r));
    end
    if ((state_r == S_AX) || ((state_r == S_OP) && wb)) begin
      acc_nxt = '0;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    axis_nxt      = axis_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_data.kind == obbov_pkg::KIND_TEST)) begin
          state_nxt = S_AX;
          axis_nxt  = '0;
          k_nxt     = '0;
        end
      end
      S_AX: begin
        if (!is_face) begin
          state_nxt = S_OP;
          op_nxt    = OP_LC;
          k_nxt     = '0;
          cnt_nxt   = '0;
        end else if (k_r == 2'd2) begin
          state_nxt = S_OP;
          op_nxt    = OP_D;
          k_nxt     = '0;
          cnt_nxt   = '0;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_OP: begin
        cnt_nxt = cnt_r + 4'd1;
        if (wb) begin
          cnt_nxt = '0;
          unique case (op_r)
            OP_LC: begin
              if (k_r == 2'd2) begin
                state_nxt = S_ZC;
                k_nxt     = '0;
              end else begin
                k_nxt = k_r + 2'd1;
              end
            end
            OP_D: begin
              state_nxt = S_RAD;
              b_nxt     = 1'b0;
            end
            OP_T: begin
              op_nxt = OP_E;
            end
            default: begin
              if (k_r == 2'd2) begin
                k_nxt = '0;
                if (!b_r) begin
                  state_nxt = S_RAD;
                  b_nxt     = 1'b1;
                end else begin
                  state_nxt = S_CMP;
                end
              end else begin
                op_nxt = OP_T;
                k_nxt  = k_r + 2'd1;
              end
            end
          endcase
        end
      end
      S_ZC: begin
        if (all_zero) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_OP;
          op_nxt    = OP_D;
          cnt_nxt   = '0;
        end
      end
      S_RAD: begin
        if (own_b) begin
          state_nxt = S_OWN;
        end else begin
          state_nxt = S_OP;
          op_nxt    = OP_T;
          k_nxt     = '0;
          cnt_nxt   = '0;
        end
      end
      S_OWN: begin
        if (!b_r) begin
          state_nxt = S_RAD;
          b_nxt     = 1'b1;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sep) begin
          state_nxt                   = S_IDLE;
          out_valid_nxt               = 1'b1;
          out_nxt.overlap             = 1'b0;
          out_nxt.separating_axis     = axis_r;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (axis_r == obbov_pkg::AXIS_LAST) begin
          state_nxt               = S_IDLE;
          out_valid_nxt           = 1'b1;
          out_nxt.overlap         = 1'b1;
          out_nxt.separating_axis = obbov_pkg::AXIS_NONE;
        end else begin
          state_nxt = S_AX;
          axis_nxt  = axis_r + 4'd1;
          k_nxt     = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_LC;
      axis_r      <= '0;
      b_r         <= 1'b0;
      k_r         <= '0;
      cnt_r       <= '0;
      opv_r       <= 1'b0;
      prodv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      axis_r      <= axis_nxt;
      b_r         <= b_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      opv_r       <= (state_r == S_OP) && issue;
      prodv_r     <= opv_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    xop_r    <= xop_nxt;
    yop_r    <= yfull;
    ophi_r   <= pass;
    prod_r   <= xop_r * yop_r;
    prodhi_r <= ophi_r;
    acc_r    <= acc_nxt;
    out_r    <= out_nxt;
    if (state_r == S_AX) begin
      rsum_r <= '0;
      l_r[k_r] <= own0 ? LW'(ax_a_rd) : LW'(ax_b_rd);
    end
    if (state_r == S_OWN) begin
      rsum_r <= rsum_r + (WW'(ext_sel) <<< (2 * AXIS_FRAC_BITS));
    end
    if ((state_r == S_OP) && wb) begin
      case (op_r)
        OP_LC:   l_r[k_r] <= LW'(acc_r);
        OP_D:    dabs_r   <= acc_abs;
        OP_T:    t_r      <= acc_abs[TW-1:0];
        default: rsum_r   <= rsum_r + acc_r;
      endcase
    end
  end

  // box storage writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cen_a_r[i] <= '0;
        cen_b_r[i] <= '0;
        ext_a_r[i] <= '0;
        ext_b_r[i] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        ax_a_r[i] <= '0;
        ax_b_r[i] <= '0;
      end
    end else if (accept && (in_data.kind == obbov_pkg::KIND_LOAD)) begin
      case (in_data.slot) inside
        obbov_pkg::SLOT_CENTER: begin
          if (in_data.box_sel) begin
            cen_b_r[0] <= CW'(in_data.x);
            cen_b_r[1] <= CW'(in_data.y);
            cen_b_r[2] <= CW'(in_data.z);
          end else begin
            cen_a_r[0] <= CW'(in_data.x);
            cen_a_r[1] <= CW'(in_data.y);
            cen_a_r[2] <= CW'(in_data.z);
          end
        end
        obbov_pkg::SLOT_AXIS0, obbov_pkg::SLOT_AXIS1, obbov_pkg::SLOT_AXIS2: begin
          if (in_data.box_sel) begin
            ax_b_r[ld_base]        <= AW'(in_data.x);
            ax_b_r[ld_base + 4'd1] <= AW'(in_data.y);
            ax_b_r[ld_base + 4'd2] <= AW'(in_data.z);
          end else begin
            ax_a_r[ld_base]        <= AW'(in_data.x);
            ax_a_r[ld_base + 4'd1] <= AW'(in_data.y);
            ax_a_r[ld_base + 4'd2] <= AW'(in_data.z);
          end
        end
        obbov_pkg::SLOT_EXT: begin
          if (in_data.box_sel) begin
            ext_b_r[0] <= CW'(in_data.x);
            ext_b_r[1] <= CW'(in_data.y);
            ext_b_r[2] <= CW'(in_data.z);
          end else begin
            ext_a_r[0] <= CW'(in_data.x);
            ext_a_r[1] <= CW'(in_data.y);
            ext_a_r[2] <= CW'(in_data.z);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result only follows a test that was in progress
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a test in progress");

  // overlap flag agrees with the reported axis
  a_out_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.overlap == (out_data.separating_axis == obbov_pkg::AXIS_NONE)))
    else $error("overlap flag and separating axis disagree");

  // a load word never makes the block busy
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.kind == obbov_pkg::KIND_LOAD)) |=> !busy)
    else $error("load word started a test");

  // every dot operation starts from a cleared accumulator
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OP) && (cnt_r == '0)) |-> (acc_r == '0))
    else $error("accumulator not cleared at start of operation");

endmodule
